FILE: rtl/core/fcct_pkg.sv
// Shared types, constants and helpers of the four-channel counter/timer.
// Used by fcct_chan and four_channel_counter_timer; depends on nothing else.
`default_nettype none

package fcct_pkg;

  localparam int NumChannels = 4;
  localparam int ChanW       = 2;
  localparam int CountW      = 17;

  typedef enum logic [1:0] {
    ReqWrite = 2'd0,
    ReqRead  = 2'd1,
    ReqTick  = 2'd2
  } req_e;

  // Control word bit positions.
  localparam int CwIntEnable   = 7;
  localparam int CwCounterMode = 6;
  localparam int CwPrescale256 = 5;
  localparam int CwConstFollow = 2;
  localparam int CwReset       = 1;
  localparam int CwIsControl   = 0;

  localparam logic [7:0] VectorMask = 8'hF8;

  typedef struct packed {
    logic       wr;
    logic       tick;
    logic       clr_pend;
    logic [7:0] data;
    logic [7:0] cycles;
  } chan_cmd_t;

  typedef struct packed {
    logic       await_const;
    logic       pend;
    logic [7:0] rd_val;
  } chan_stat_t;

  // Reload value: time constant (zero meaning 256) times the prescale.
  function automatic logic [CountW-1:0] reload_val(input logic [7:0] tc, input logic pre256);
    logic [8:0] k;
    k = (tc == 8'd0) ? 9'd256 : {1'b0, tc};
    return pre256 ? {k, 8'b0} : {4'b0, k, 4'b0};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fcct_chan.sv
// One timer channel: control word, time constant, down counter and pending flag.
// Depends on fcct_pkg.
`default_nettype none

module fcct_chan (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire fcct_pkg::chan_cmd_t cmd_i,
  output fcct_pkg::chan_stat_t stat_o
);
  import fcct_pkg::*;

  logic [7:0]        cw_q, cw_d;
  logic [7:0]        tc_q, tc_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              await_q, await_d;
  logic              pend_q, pend_d;
  logic              pend_after;
  logic              running;
  logic [CountW-1:0] reload_cur;

  assign reload_cur = reload_val(tc_q, cw_q[CwPrescale256]);
  assign running    = cw_q[CwIsControl] && !cw_q[CwCounterMode] && (cnt_q != '0);

  always_comb begin
    cw_d       = cw_q;
    tc_d       = tc_q;
    cnt_d      = cnt_q;
    await_d    = await_q;
    pend_after = pend_q;
    if (cmd_i.tick && running) begin
      if (cnt_q <= {{(CountW-8){1'b0}}, cmd_i.cycles}) begin
        // Reload once; whatever overshoot there was is dropped.
        cnt_d = reload_cur;
        if (cw_q[CwIntEnable]) begin
          pend_after = 1'b1;
        end
      end else begin
        cnt_d = cnt_q - {{(CountW-8){1'b0}}, cmd_i.cycles};
      end
    end
    pend_d = pend_after && !cmd_i.clr_pend;
    if (cmd_i.wr) begin
      if (await_q) begin
        tc_d    = cmd_i.data;
        await_d = 1'b0;
        cnt_d   = reload_val(cmd_i.data, cw_q[CwPrescale256]);
      end else if (cmd_i.data[CwIsControl]) begin
        cw_d = cmd_i.data;
        if (cmd_i.data[CwConstFollow]) begin
          await_d = 1'b1;
        end
        if (cmd_i.data[CwReset]) begin
          cnt_d  = '0;
          pend_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q    <= '0;
      tc_q    <= '0;
      cnt_q   <= '0;
      await_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      cw_q    <= cw_d;
      tc_q    <= tc_d;
      cnt_q   <= cnt_d;
      await_q <= await_d;
      pend_q  <= pend_d;
    end
  end

  assign stat_o.await_const = await_q;
  assign stat_o.pend        = pend_after;
  assign stat_o.rd_val      = cw_q[CwPrescale256] ? cnt_q[15:8] : cnt_q[11:4];

endmodule

`default_nettype wire

FILE: rtl/core/four_channel_counter_timer.sv
// Four-channel counter/timer, top level: input register, then result register.
// Throughput is one transaction per cycle while the output is not stalled; the only
// loop is the channel state update, closing in the single processing stage after the
// input register. Reset (rst_ni low, asynchronous) clears all channel state, the
// vector base and both pipeline valid flags. Depends on fcct_pkg and fcct_chan.
`default_nettype none

module four_channel_counter_timer (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  [1:0]                  req_type_i,
  input  wire  [fcct_pkg::ChanW-1:0]  channel_i,
  input  wire  [7:0]                  data_i,
  input  wire  [7:0]                  tick_cycles_i,
  input  wire                         cpu_int_enabled_i,
  input  wire                         cpu_int_busy_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [7:0]                  read_data_o,
  output logic                        int_request_o,
  output logic [7:0]                  int_vector_o
);
  import fcct_pkg::*;

  // Input register. A transaction sits here while the channel state is
  // consulted, and moves on once the result register has room.
  logic              in_valid_q, in_valid_d;
  logic [1:0]        req_q;
  logic [ChanW-1:0]  chan_q;
  logic [7:0]        data_q;
  logic [7:0]        cycles_q;
  logic              int_en_q;
  logic              int_busy_q;

  logic              accept;
  logic              advance;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [7:0]        rd_q, rd_d;
  logic              irq_q, irq_d;
  logic [7:0]        vec_q, vec_d;

  logic [7:0]        vbase_q, vbase_d;

  chan_cmd_t         cmd   [NumChannels];
  chan_stat_t        stat  [NumChannels];
  logic              chan_ok;
  logic              is_wr, is_rd, is_tick;
  logic              deliver;
  logic [ChanW-1:0]  gnt_idx;
  logic              gnt_any;

  // The result register frees up when it is empty or being taken this cycle,
  // so the input side only stalls while a finished result is held by a stall.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign chan_ok = {1'b0, chan_q} < (ChanW+1)'(NumChannels);
  assign is_wr   = advance && (req_q == ReqWrite);
  assign is_rd   = advance && (req_q == ReqRead);
  assign is_tick = advance && (req_q == ReqTick);
  assign deliver = is_tick && int_en_q && !int_busy_q;

  // Lowest-numbered pending channel wins the interrupt. The scan runs from
  // the top down so that the last hit is the lowest index.
  always_comb begin
    gnt_any = 1'b0;
    gnt_idx = '0;
    for (int i = NumChannels - 1; i >= 0; i--) begin
      if (stat[i].pend) begin
        gnt_any = 1'b1;
        gnt_idx = ChanW'(i);
      end
    end
  end

  for (genvar g = 0; g < NumChannels; g++) begin : g_chan
    always_comb begin
      cmd[g].wr       = is_wr && chan_ok && (chan_q == ChanW'(g));
      cmd[g].tick     = is_tick;
      cmd[g].clr_pend = deliver && gnt_any && (gnt_idx == ChanW'(g));
      cmd[g].data     = data_q;
      cmd[g].cycles   = cycles_q;
    end

    fcct_chan u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .stat_o (stat[g])
    );
  end

  // The vector base is shared and only written through channel 0, with a
  // byte that is neither a time constant nor a control word.
  always_comb begin
    vbase_d = vbase_q;
    if (is_wr && (chan_q == '0) && !stat[0].await_const && !data_q[CwIsControl]) begin
      vbase_d = data_q & VectorMask;
    end
  end

  always_comb begin
    rd_d  = '0;
    irq_d = 1'b0;
    vec_d = '0;
    if (is_rd && chan_ok) begin
      rd_d = stat[chan_q].rd_val;
    end
    if (deliver && gnt_any) begin
      irq_d = 1'b1;
      vec_d = vbase_q | {{(7-ChanW){1'b0}}, gnt_idx, 1'b0};
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vbase_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      vbase_q     <= vbase_d;
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_type_i;
      chan_q     <= channel_i;
      data_q     <= data_i;
      cycles_q   <= tick_cycles_i;
      int_en_q   <= cpu_int_enabled_i;
      int_busy_q <= cpu_int_busy_i;
    end
    if (advance) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
      vec_q <= vec_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_q;
  assign int_request_o = irq_q;
  assign int_vector_o  = vec_q;

endmodule

`default_nettype wire

FILE: rtl/core/fcct_checker.sv
// Port-level checks for four_channel_counter_timer, attached by bind.
// Depends on the top level's port list only.
`default_nettype none

module fcct_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_stall_o,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [7:0] read_data_o,
  input wire       int_request_o,
  input wire [7:0] int_vector_o
);

  // A result waiting on a stall stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The input side only backs up when the result side is full and stalled.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A transaction without an interrupt carries no vector.
  a_vec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !int_request_o |-> int_vector_o == 8'd0)
    else $error("vector without interrupt");

  // Interrupts come only from ticks, which never return read data.
  a_irq_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && int_request_o |-> read_data_o == 8'd0 && !int_vector_o[0])
    else $error("interrupt result carries read data or odd vector");

endmodule

bind four_channel_counter_timer fcct_checker u_fcct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .read_data_o   (read_data_o),
  .int_request_o (int_request_o),
  .int_vector_o  (int_vector_o)
);

`default_nettype wire
